### design/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// Types, key codes and decode functions for the terminal key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tksd_pkg;

  localparam int BUFFER_DEPTH_DEF = 10;

  localparam logic [7:0] ESC_BYTE      = 8'd27;
  localparam logic [7:0] TILDE         = 8'h7E;
  localparam logic [7:0] CH_BKSP       = 8'd8;
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;
  localparam logic [3:0] MOD_NONE      = 4'd0;
  localparam logic [3:0] MOD_BAD       = 4'd15;

  localparam logic [4:0] KEY_UNKNOWN     = 5'd0;
  localparam logic [4:0] KEY_ESC         = 5'd1;
  localparam logic [4:0] KEY_ARROW_UP    = 5'd2;
  localparam logic [4:0] KEY_ARROW_DOWN  = 5'd3;
  localparam logic [4:0] KEY_ARROW_RIGHT = 5'd4;
  localparam logic [4:0] KEY_ARROW_LEFT  = 5'd5;
  localparam logic [4:0] KEY_NAV_HOME    = 5'd6;
  localparam logic [4:0] KEY_NAV_END     = 5'd7;
  localparam logic [4:0] KEY_PAGE_UP     = 5'd8;
  localparam logic [4:0] KEY_PAGE_DOWN   = 5'd9;
  localparam logic [4:0] KEY_DEL         = 5'd10;
  localparam logic [4:0] KEY_INS         = 5'd11;
  localparam logic [4:0] KEY_F1          = 5'd12;
  localparam logic [4:0] KEY_F2          = 5'd13;
  localparam logic [4:0] KEY_F3          = 5'd14;
  localparam logic [4:0] KEY_F4          = 5'd15;
  localparam logic [4:0] KEY_F5          = 5'd16;
  localparam logic [4:0] KEY_F6          = 5'd17;
  localparam logic [4:0] KEY_F7          = 5'd18;
  localparam logic [4:0] KEY_F8          = 5'd19;
  localparam logic [4:0] KEY_F9          = 5'd20;
  localparam logic [4:0] KEY_F10         = 5'd21;
  localparam logic [4:0] KEY_F11         = 5'd22;
  localparam logic [4:0] KEY_F12         = 5'd23;
  localparam logic [4:0] KEY_BKSP        = 5'd24;
  localparam logic [4:0] KEY_ENTER       = 5'd25;
  localparam logic [4:0] KEY_TAB         = 5'd26;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_COLLECT = 2'b10
  } state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0] key_code;
    logic [3:0] modifier_code;
    logic       from_escape;
    logic [3:0] sequence_length;
  } out_item_t;

  typedef struct packed {
    logic [4:0] key;
    logic [3:0] modifier;
  } dec_t;

  function automatic logic [3:0] mod_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - "0";
    if (c >= "0" && c <= "9") begin
      return diff[3:0];
    end
    return MOD_BAD;
  endfunction

  function automatic logic [4:0] fkey_of(input logic [7:0] c);
    case (c)
      "5", "6": return KEY_F5;
      "7":      return KEY_F6;
      "8":      return KEY_F7;
      "9":      return KEY_F8;
      "0":      return KEY_F9;
      "1":      return KEY_F10;
      "3":      return KEY_F11;
      "4":      return KEY_F12;
      default:  return KEY_UNKNOWN;
    endcase
  endfunction

  function automatic logic [4:0] letter_of(input logic [7:0] c);
    case (c)
      "A":     return KEY_ARROW_UP;
      "B":     return KEY_ARROW_DOWN;
      "C":     return KEY_ARROW_RIGHT;
      "D":     return KEY_ARROW_LEFT;
      "H":     return KEY_NAV_HOME;
      "F":     return KEY_NAV_END;
      "P":     return KEY_F1;
      "Q":     return KEY_F2;
      "R":     return KEY_F3;
      "S":     return KEY_F4;
      default: return KEY_UNKNOWN;
    endcase
  endfunction

  // Decodes a sequence of the given length from the bytes at positions 1..5.
  function automatic dec_t decode_seq(input logic [4:0] len, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [7:0] b4, input logic [7:0] b5);
    dec_t       d;
    logic [4:0] k;
    d.key      = KEY_UNKNOWN;
    d.modifier = MOD_NONE;
    k          = KEY_UNKNOWN;
    case (len)
      5'd0: d.key = KEY_ESC;
      5'd2: d.key = letter_of(b1);
      5'd3: begin
        if (b2 == TILDE) begin
          case (b1)
            "1":     d.key = KEY_NAV_HOME;
            "4":     d.key = KEY_NAV_END;
            "5":     d.key = KEY_PAGE_UP;
            "6":     d.key = KEY_PAGE_DOWN;
            "3":     d.key = KEY_DEL;
            "2":     d.key = KEY_INS;
            default: d.key = KEY_UNKNOWN;
          endcase
        end
      end
      5'd4: begin
        if (b3 == TILDE) begin
          d.key = fkey_of(b2);
        end
      end
      5'd5: begin
        if (b4 == TILDE) begin
          if (b1 == "3") begin
            d.key = KEY_DEL;
          end else if (b1 == "2") begin
            d.key = KEY_INS;
          end
          d.modifier = mod_of(b3);
        end else begin
          k     = letter_of(b4);
          d.key = k;
          // Only a recognized final letter carries its modifier; an unknown letter
          // is reported with no modifier.
          if (k != KEY_UNKNOWN) begin
            d.modifier = mod_of(b3);
          end
        end
      end
      5'd6: begin
        if (b5 == TILDE) begin
          k     = fkey_of(b2);
          d.key = k;
          if (k != KEY_UNKNOWN) begin
            d.modifier = mod_of(b4);
          end
        end
      end
      default: d.key = KEY_UNKNOWN;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### design/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Decodes terminal bytes and millisecond ticks into key press reports.
// ----------------------------------------------------------------------------
//
//   channel   ports                       direction  payload
//   in        in_valid/in_ready/in_item   input      command, data_byte
//   out       out_valid/out_ready/out_item output    key, modifier, escape, length
//   cfg       cfg_we/cfg_wdata            input      timeout_ticks
//
// One transaction is taken every cycle; its result, if any, shows on the
// output register in the cycle after acceptance. The decode is a single pass of
// compare logic from the sequence registers to the output register.
// Input is stalled only while a result waits and out_ready is low.
// Synchronous active-low reset returns to idle with timeout 5.
//
`default_nettype none

module terminal_key_sequence_decoder #(
  parameter int BUFFER_DEPTH = tksd_pkg::BUFFER_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire tksd_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output tksd_pkg::out_item_t  out_item,
  input  wire                  cfg_we,
  input  wire  [7:0]           cfg_wdata
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W = $clog2(BUFFER_DEPTH);

  tksd_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [7:0]          elapsed_r, elapsed_nxt;
  logic [7:0]          timeout_r;
  logic [7:0]          seq_r [BUFFER_DEPTH];
  logic                out_valid_r, out_valid_nxt;
  tksd_pkg::out_item_t out_item_r, out_item_nxt;

  logic                in_fire;
  logic                store;
  logic [CNT_W-1:0]    cnt_inc;
  logic [7:0]          elapsed_inc;
  logic [7:0]          view [1:5];
  logic [4:0]          dec_len;
  tksd_pkg::dec_t      dec;
  logic                emit;
  logic [4:0]          single_key;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign elapsed_inc = (elapsed_r == 8'hFF) ? elapsed_r : elapsed_r + 8'd1;

  // A nonzero byte while collecting with room left is stored.
  assign store = (state_r == tksd_pkg::ST_COLLECT) && !in_item.command &&
                 (in_item.data_byte != 8'd0) && (cnt_r < CNT_W'(BUFFER_DEPTH));

  // The decoder sees the held bytes with the incoming byte already in place.
  always_comb begin
    for (int i = 1; i <= 5; i++) begin
      view[i] = (store && cnt_r == CNT_W'(i)) ? in_item.data_byte : seq_r[i];
    end
  end

  assign dec_len = store ? 5'(cnt_inc) : 5'(cnt_r);
  assign dec     = tksd_pkg::decode_seq(dec_len, view[1], view[2], view[3],
                                        view[4], view[5]);

  always_comb begin
    case (in_item.data_byte)
      tksd_pkg::CH_BKSP:              single_key = tksd_pkg::KEY_BKSP;
      tksd_pkg::CH_LF, tksd_pkg::CH_CR: single_key = tksd_pkg::KEY_ENTER;
      tksd_pkg::CH_TAB:               single_key = tksd_pkg::KEY_TAB;
      default:                        single_key = tksd_pkg::KEY_UNKNOWN;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    elapsed_nxt  = elapsed_r;
    emit         = 1'b0;
    out_item_nxt = out_item_r;
    unique case (state_r)
      tksd_pkg::ST_IDLE: begin
        if (in_fire && !in_item.command) begin
          if (in_item.data_byte == tksd_pkg::ESC_BYTE) begin
            state_nxt   = tksd_pkg::ST_COLLECT;
            cnt_nxt     = '0;
            elapsed_nxt = 8'd0;
          end else begin
            emit                         = 1'b1;
            out_item_nxt.key_code        = single_key;
            out_item_nxt.modifier_code   = tksd_pkg::MOD_NONE;
            out_item_nxt.from_escape     = 1'b0;
            out_item_nxt.sequence_length = 4'd0;
          end
        end
      end
      tksd_pkg::ST_COLLECT: begin
        if (in_fire) begin
          if (in_item.command) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= timeout_r) begin
              emit                         = 1'b1;
              state_nxt                    = tksd_pkg::ST_IDLE;
              out_item_nxt.key_code        = dec.key;
              out_item_nxt.modifier_code   = dec.modifier;
              out_item_nxt.from_escape     = 1'b1;
              out_item_nxt.sequence_length = 4'(cnt_r);
            end
          end else if (store) begin
            cnt_nxt = cnt_inc;
            if (dec.key != tksd_pkg::KEY_UNKNOWN) begin
              emit                         = 1'b1;
              state_nxt                    = tksd_pkg::ST_IDLE;
              out_item_nxt.key_code        = dec.key;
              out_item_nxt.modifier_code   = dec.modifier;
              out_item_nxt.from_escape     = 1'b1;
              out_item_nxt.sequence_length = 4'(cnt_inc);
            end
          end
        end
      end
      default: state_nxt = tksd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tksd_pkg::ST_IDLE;
      cnt_r       <= '0;
      elapsed_r   <= 8'd0;
      timeout_r   <= tksd_pkg::TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
    if (in_fire && store) begin
      seq_r[cnt_r[IDX_W-1:0]] <= in_item.data_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BUFFER_DEPTH))
    else $error("collected count exceeds buffer depth");

  a_single_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.from_escape |->
      out_item_r.modifier_code == tksd_pkg::MOD_NONE &&
      out_item_r.sequence_length == 4'd0)
    else $error("single character result carries escape fields");

  a_esc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.key_code == tksd_pkg::KEY_ESC |->
      out_item_r.from_escape && out_item_r.sequence_length == 4'd0)
    else $error("escape key reported with collected bytes");

  a_esc_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && state_r == tksd_pkg::ST_IDLE && !in_item.command &&
      in_item.data_byte == tksd_pkg::ESC_BYTE |=>
      state_r == tksd_pkg::ST_COLLECT && cnt_r == '0 && elapsed_r == 8'd0)
    else $error("ESC did not start a fresh sequence");

endmodule

`default_nettype wire
